@@ hdl/mpr_pkg.sv @@
// Shared types, turn codes and helper functions for the maze path recorder.
// No dependencies; used by maze_path_recorder_reducer.
package mpr_pkg;

    localparam logic [1:0] TURN_L = 2'd0;
    localparam logic [1:0] TURN_S = 2'd1;
    localparam logic [1:0] TURN_R = 2'd2;
    localparam logic [1:0] TURN_B = 2'd3;

    localparam logic OP_LEARN = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_RDATA,
        ST_MID,
        ST_FIRST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       hit;
        logic [1:0] repl;
    } t_rewrite;

    // Left-hand rule: left, then straight, then right, else back.
    function automatic logic [1:0] choose_turn(input logic left, input logic straight,
                                               input logic right);
        logic [1:0] t;
        if (left) begin
            t = TURN_L;
        end else if (straight) begin
            t = TURN_S;
        end else if (right) begin
            t = TURN_R;
        end else begin
            t = TURN_B;
        end
        return t;
    endfunction

    // Dead-end rewrite of first, back, last into a single entry.
    function automatic t_rewrite reduce_triple(input logic [1:0] first, input logic [1:0] last);
        t_rewrite r;
        r.hit  = 1'b1;
        r.repl = TURN_B;
        if ((first == TURN_L && last == TURN_R) || (first == TURN_R && last == TURN_L) ||
            (first == TURN_S && last == TURN_S)) begin
            r.repl = TURN_B;
        end else if (first == TURN_L && last == TURN_L) begin
            r.repl = TURN_S;
        end else if ((first == TURN_S && last == TURN_L) ||
                     (first == TURN_L && last == TURN_S)) begin
            r.repl = TURN_R;
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ hdl/mpr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mpr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/maze_path_recorder_reducer.sv @@
// Maze path recorder: left-hand turn choice, path stack in RAM, dead-end rewrite.
// A learn item pushes its turn unless the path is full; with two or more entries below it,
// it then reads the entry below the top and, if that is back, the entry beneath it. A read
// item reads the indexed entry from RAM when the index lies within the path.
// Items are taken one at a time: o_stall stays high until the finished item is loaded out.
// Reset clears the entry count and the control state; the path RAM is not cleared.
// Depends on mpr_pkg and mpr_ram.
module maze_path_recorder_reducer #(
    parameter int PATH_DEPTH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_op,
    input  logic       i_exit_left,
    input  logic       i_exit_straight,
    input  logic       i_exit_right,
    input  logic [6:0] i_read_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_turn,
    output logic [1:0] o_entry,
    output logic [7:0] o_length,
    output logic       o_reduced,
    output logic       o_overflow
);

    localparam int AW   = $clog2(PATH_DEPTH);
    localparam int CW   = $clog2(PATH_DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    mpr_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic          r_op;
    logic [1:0]    r_turn;
    logic [6:0]    r_idx;
    logic [1:0]    r_entry, n_entry;
    logic          r_reduced, n_reduced;
    logic          r_overflow, n_overflow;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_o_turn, r_o_entry;
    logic [7:0]    r_o_length;
    logic          r_o_reduced, r_o_overflow;
    logic          load_out;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [1:0]    ram_wdata, ram_rdata;

    mpr_pkg::t_rewrite rw;

    mpr_ram #(
        .WIDTH(2),
        .DEPTH(PATH_DEPTH)
    ) u_path_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rw = mpr_pkg::reduce_triple(ram_rdata, r_turn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mpr_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mpr_pkg::ST_IDLE && i_valid) begin
            r_op   <= i_op;
            r_turn <= mpr_pkg::choose_turn(i_exit_left, i_exit_straight, i_exit_right);
            r_idx  <= i_read_index;
        end
        r_entry    <= n_entry;
        r_reduced  <= n_reduced;
        r_overflow <= n_overflow;
        if (load_out) begin
            r_o_turn     <= (r_op == mpr_pkg::OP_READ) ? mpr_pkg::TURN_L : r_turn;
            r_o_entry    <= r_entry;
            r_o_length   <= 8'(r_count);
            r_o_reduced  <= r_reduced;
            r_o_overflow <= r_overflow;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_entry     = r_entry;
        n_reduced   = r_reduced;
        n_overflow  = r_overflow;
        n_out_valid = r_out_valid && i_stall;
        load_out    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = AW'(r_count);
        ram_wdata   = r_turn;
        ram_re      = 1'b0;
        ram_raddr   = AW'(r_count - CW'(1));

        unique case (r_state)
            mpr_pkg::ST_IDLE: begin
                n_entry    = 2'd0;
                n_reduced  = 1'b0;
                n_overflow = 1'b0;
                if (i_valid) begin
                    n_state = mpr_pkg::ST_ISSUE;
                end
            end
            mpr_pkg::ST_ISSUE: begin
                if (r_op == mpr_pkg::OP_READ) begin
                    if (CMPW'(r_idx) < CMPW'(r_count)) begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(r_idx);
                        n_state   = mpr_pkg::ST_RDATA;
                    end else begin
                        n_state = mpr_pkg::ST_DONE;
                    end
                end else if (r_count >= CW'(PATH_DEPTH)) begin
                    n_overflow = 1'b1;
                    n_state    = mpr_pkg::ST_DONE;
                end else begin
                    // Push the new turn; the rewrite needs the two entries below it.
                    ram_we = 1'b1;
                    if (r_count >= CW'(2)) begin
                        ram_re  = 1'b1;
                        n_state = mpr_pkg::ST_MID;
                    end else begin
                        n_count = r_count + CW'(1);
                        n_state = mpr_pkg::ST_DONE;
                    end
                end
            end
            mpr_pkg::ST_RDATA: begin
                n_entry = ram_rdata;
                n_state = mpr_pkg::ST_DONE;
            end
            mpr_pkg::ST_MID: begin
                if (ram_rdata == mpr_pkg::TURN_B) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_count - CW'(2));
                    n_state   = mpr_pkg::ST_FIRST;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = mpr_pkg::ST_DONE;
                end
            end
            mpr_pkg::ST_FIRST: begin
                if (rw.hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_count - CW'(2));
                    ram_wdata = rw.repl;
                    n_count   = r_count - CW'(1);
                    n_reduced = 1'b1;
                end else begin
                    n_count = r_count + CW'(1);
                end
                n_state = mpr_pkg::ST_DONE;
            end
            mpr_pkg::ST_DONE: begin
                // Hold the finished item until the output register is free.
                if (!r_out_valid || !i_stall) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = mpr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mpr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_stall    = (r_state != mpr_pkg::ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_turn     = r_o_turn;
    assign o_entry    = r_o_entry;
    assign o_length   = r_o_length;
    assign o_reduced  = r_o_reduced;
    assign o_overflow = r_o_overflow;

endmodule

@@ test/tb_maze_path_recorder_reducer.sv @@
`timescale 1ns / 1ps
// Testbench for maze_path_recorder_reducer: directed dead-end cases, then random learn and
// read items under changing idle and stall patterns, checked by a path-stack scoreboard.
// Depends on mpr_pkg and the block's RTL.
module tb_maze_path_recorder_reducer;

    localparam int STORE_DEPTH    = 128;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [1:0] turn;
        logic [1:0] entry;
        logic [7:0] length;
        logic       reduced;
        logic       overflow;
    } t_path_result;

    class path_scoreboard;
        logic [1:0]   path_mem [STORE_DEPTH];
        int           depth_used;
        t_path_result awaited_q [$];
        int           failures;

        function new();
            depth_used = 0;
            failures   = 0;
        endfunction

        function logic [1:0] pick_turn(logic left, logic straight, logic right);
            logic [1:0] t;
            casez ({left, straight, right})
                3'b1??:  t = mpr_pkg::TURN_L;
                3'b01?:  t = mpr_pkg::TURN_S;
                3'b001:  t = mpr_pkg::TURN_R;
                default: t = mpr_pkg::TURN_B;
            endcase
            return t;
        endfunction

        function bit fold_dead_end(logic [1:0] first, logic [1:0] last,
                                   output logic [1:0] repl);
            repl = mpr_pkg::TURN_B;
            case ({first, last})
                {mpr_pkg::TURN_L, mpr_pkg::TURN_R}, {mpr_pkg::TURN_R, mpr_pkg::TURN_L},
                {mpr_pkg::TURN_S, mpr_pkg::TURN_S}: repl = mpr_pkg::TURN_B;
                {mpr_pkg::TURN_L, mpr_pkg::TURN_L}: repl = mpr_pkg::TURN_S;
                {mpr_pkg::TURN_S, mpr_pkg::TURN_L},
                {mpr_pkg::TURN_L, mpr_pkg::TURN_S}: repl = mpr_pkg::TURN_R;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void note_item(logic op, logic left, logic straight, logic right,
                                logic [6:0] idx);
            t_path_result r;
            logic [1:0]   repl;
            r = '0;
            if (op == mpr_pkg::OP_LEARN) begin
                r.turn = pick_turn(left, straight, right);
                if (depth_used == STORE_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    path_mem[depth_used] = r.turn;
                    depth_used++;
                    // Only a back turn just below the new top can close a dead end.
                    if (depth_used >= 3 && path_mem[depth_used - 2] == mpr_pkg::TURN_B) begin
                        if (fold_dead_end(path_mem[depth_used - 3], r.turn, repl)) begin
                            path_mem[depth_used - 3] = repl;
                            depth_used -= 2;
                            r.reduced = 1'b1;
                        end
                    end
                end
            end else if (idx < depth_used) begin
                r.entry = path_mem[idx];
            end
            r.length = 8'(depth_used);
            awaited_q.push_back(r);
        endfunction

        function void check_result(t_path_result got);
            t_path_result want;
            if (awaited_q.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("Result with nothing awaited: turn %0d entry %0d length %0d %0b%0b",
                             got.turn, got.entry, got.length, got.reduced, got.overflow);
                end
                return;
            end
            want = awaited_q.pop_front();
            if (got.turn !== want.turn || got.entry !== want.entry ||
                got.length !== want.length || got.reduced !== want.reduced ||
                got.overflow !== want.overflow) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("Mismatch (expected/got): turn %0d/%0d entry %0d/%0d length %0d/%0d",
                             want.turn, got.turn, want.entry, got.entry,
                             want.length, got.length);
                    $display("    reduced %0b/%0b overflow %0b/%0b",
                             want.reduced, got.reduced, want.overflow, got.overflow);
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic       o_stall;
    logic       i_op            = mpr_pkg::OP_LEARN;
    logic       i_exit_left     = 1'b0;
    logic       i_exit_straight = 1'b0;
    logic       i_exit_right    = 1'b0;
    logic [6:0] i_read_index    = '0;
    logic       o_valid;
    logic       i_stall         = 1'b0;
    logic [1:0] o_turn;
    logic [1:0] o_entry;
    logic [7:0] o_length;
    logic       o_reduced;
    logic       o_overflow;

    path_scoreboard path_tracker = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    bit shrinking     = 1'b0;
    bit filling       = 1'b0;

    maze_path_recorder_reducer #(.PATH_DEPTH(STORE_DEPTH)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result side: check what is taken, then choose the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            path_tracker.check_result({o_turn, o_entry, o_length, o_reduced, o_overflow});
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Valid is left high between items unless an idle gap is drawn.
    task automatic send_item(logic op, logic left, logic straight, logic right,
                             logic [6:0] idx);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid         <= 1'b1;
        i_op            <= op;
        i_exit_left     <= left;
        i_exit_straight <= straight;
        i_exit_right    <= right;
        i_read_index    <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        path_tracker.note_item(op, left, straight, right, idx);
    endtask

    // Exits that make the left-hand rule pick the given turn; lower-priority exits are random.
    task automatic send_learn(logic [1:0] turn);
        logic l;
        logic s;
        logic r;
        l = (turn == mpr_pkg::TURN_L);
        s = (turn == mpr_pkg::TURN_S) || (turn == mpr_pkg::TURN_L && $urandom_range(1));
        r = (turn == mpr_pkg::TURN_R) ||
            ((turn == mpr_pkg::TURN_L || turn == mpr_pkg::TURN_S) && $urandom_range(1));
        send_item(mpr_pkg::OP_LEARN, l, s, r, 7'($urandom));
    endtask

    task automatic send_read(logic [6:0] idx);
        send_item(mpr_pkg::OP_READ, 1'($urandom), 1'($urandom), 1'($urandom), idx);
    endtask

    function automatic logic [1:0] any_open_turn();
        case ($urandom_range(2))
            0:       return mpr_pkg::TURN_L;
            1:       return mpr_pkg::TURN_S;
            default: return mpr_pkg::TURN_R;
        endcase
    endfunction

    function automatic logic [1:0] plan_turn();
        int         n;
        logic [1:0] top;
        logic [1:0] first;
        n     = path_tracker.depth_used;
        top   = (n >= 1) ? path_tracker.path_mem[n - 1] : mpr_pkg::TURN_L;
        first = (n >= 2) ? path_tracker.path_mem[n - 2] : mpr_pkg::TURN_B;
        // While filling, never give a rewrite a chance so that the path only grows.
        if (filling && n < STORE_DEPTH) begin
            return (top == mpr_pkg::TURN_B) ? mpr_pkg::TURN_B : any_open_turn();
        end
        if ($urandom_range(99) < 10) begin
            return 2'($urandom);
        end
        if (n >= 2 && top == mpr_pkg::TURN_B && first != mpr_pkg::TURN_B) begin
            if (shrinking) begin
                // Folding into a back turn lets the entry beneath fold next, unless that
                // entry is itself back, which would leave a back on back that never folds.
                if (n >= 3 && path_tracker.path_mem[n - 3] == mpr_pkg::TURN_B &&
                    first != mpr_pkg::TURN_R) begin
                    return (first == mpr_pkg::TURN_S || $urandom_range(1)) ? mpr_pkg::TURN_L
                                                                          : mpr_pkg::TURN_S;
                end
                return (first == mpr_pkg::TURN_L) ? mpr_pkg::TURN_R :
                       (first == mpr_pkg::TURN_R) ? mpr_pkg::TURN_L : mpr_pkg::TURN_S;
            end
            case (first)
                mpr_pkg::TURN_L: return any_open_turn();
                mpr_pkg::TURN_S: return $urandom_range(1) ? mpr_pkg::TURN_S : mpr_pkg::TURN_L;
                default:         return mpr_pkg::TURN_L;
            endcase
        end
        if (top != mpr_pkg::TURN_B && $urandom_range(99) < (shrinking ? 70 : 30)) begin
            return mpr_pkg::TURN_B;
        end
        return any_open_turn();
    endfunction

    task automatic random_item();
        int n;
        n = path_tracker.depth_used;
        if (n > 100) begin
            shrinking = 1'b1;
        end else if (n < 24) begin
            shrinking = 1'b0;
        end
        if ($urandom_range(99) < 20) begin
            send_read((n > 0 && $urandom_range(99) < 85) ? 7'($urandom_range(n - 1))
                                                          : 7'($urandom));
        end else begin
            send_learn(plan_turn());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(mpr_pkg::OP_READ, 1'b0, 1'b0, 1'b0, 7'd0);
        send_learn(mpr_pkg::TURN_B);
        send_learn(mpr_pkg::TURN_S);   // back below the top, but only two entries exist
        send_learn(mpr_pkg::TURN_B);
        send_learn(mpr_pkg::TURN_R);   // straight, back, right has no rewrite
        send_learn(mpr_pkg::TURN_B);
        send_learn(mpr_pkg::TURN_B);   // back as the last of a triple
        // Back as the first of a triple.
        send_item(mpr_pkg::OP_LEARN, 1'b1, 1'b1, 1'b1, 7'd127);
        send_learn(mpr_pkg::TURN_B);
        send_learn(mpr_pkg::TURN_R);
        send_learn(mpr_pkg::TURN_S);
        send_learn(mpr_pkg::TURN_B);
        send_learn(mpr_pkg::TURN_S);
        send_learn(mpr_pkg::TURN_L);
        send_learn(mpr_pkg::TURN_B);
        send_learn(mpr_pkg::TURN_L);
        send_learn(mpr_pkg::TURN_B);
        send_learn(mpr_pkg::TURN_L);
        send_learn(mpr_pkg::TURN_B);
        send_learn(mpr_pkg::TURN_L);
        send_learn(mpr_pkg::TURN_L);
        send_learn(mpr_pkg::TURN_B);
        send_learn(mpr_pkg::TURN_S);
        send_read(7'(path_tracker.depth_used - 1));
        send_read(7'(path_tracker.depth_used));   // just past the end of the path
        send_read(7'd127);

        repeat (40) random_item();
        // The receiver holds off while items keep coming, so the block backs up.
        hold_request = 300;
        repeat (260) random_item();
        send_idle_pct = 77;
        repeat (300) random_item();
        send_idle_pct = 0;
        stall_pct     = 77;
        repeat (300) random_item();
        send_idle_pct = 30;
        stall_pct     = 30;
        repeat (300) random_item();

        // Fill the store, then keep learning into a full one.
        filling = 1'b1;
        while (path_tracker.depth_used < STORE_DEPTH) random_item();
        hold_request = 200;
        repeat (60) random_item();

        i_valid   <= 1'b0;
        stall_pct = 0;
        while (path_tracker.awaited_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (path_tracker.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
